/* src/sohm_pkg.sv */
// ----------------------------------------------------------------------------
// sohm_pkg: shared types and constants
// Field widths, mixing shift amounts and the job record that is passed from
// the byte front end to the finalize/modulo back end.
// ----------------------------------------------------------------------------
package sohm_pkg;

    localparam int HASH_W = 32;
    localparam int SIZE_W = 16;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = $clog2(HASH_W);

    // per-byte mixing shifts
    localparam int MIX_SHL = 10;
    localparam int MIX_SHR = 6;

    // final avalanche shifts
    localparam int FIN_SHL_A = 3;
    localparam int FIN_SHR   = 11;
    localparam int FIN_SHL_B = 15;

    // one finished key waiting for finalize and modulo
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [SIZE_W-1:0] size;
    } t_job;

endpackage

/* src/sohm_front.sv */
// ----------------------------------------------------------------------------
// sohm_front: per-byte hash mixing
// Takes one key byte per cycle while the queue has room, keeps the running
// hash, seed and size of the open key, and queues its mixed hash when done.
// ----------------------------------------------------------------------------
module sohm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sohm_pkg::BYTE_W-1:0] i_key_byte,
    input  logic [sohm_pkg::HASH_W-1:0] i_seed,
    input  logic [sohm_pkg::SIZE_W-1:0] i_table_size,
    input  logic                        i_last_byte,
    input  logic                        i_job_full,
    output logic                        o_job_push,
    output sohm_pkg::t_job              o_job
);

    logic [sohm_pkg::HASH_W-1:0] r_hash, n_hash;
    logic [sohm_pkg::HASH_W-1:0] r_seed, n_seed;
    logic [sohm_pkg::SIZE_W-1:0] r_size, n_size;
    logic                        r_inside, n_inside;

    logic                        accept;
    logic [sohm_pkg::HASH_W-1:0] seed_use;
    logic [sohm_pkg::SIZE_W-1:0] size_use;
    logic [sohm_pkg::HASH_W-1:0] hash_base;
    logic [sohm_pkg::HASH_W-1:0] byte_ext;
    logic [sohm_pkg::HASH_W-1:0] sum_a;
    logic [sohm_pkg::HASH_W-1:0] sum_b;
    logic [sohm_pkg::HASH_W-1:0] mixed;

    assign o_ready = !i_job_full;
    assign accept  = i_valid && o_ready;

    // seed and size are taken on the first byte of a key
    assign seed_use  = r_inside ? r_seed : i_seed;
    assign size_use  = r_inside ? r_size : i_table_size;
    assign hash_base = r_inside ? r_hash : '0;

    // signed byte plus seed, then shift-add and xor-shift
    assign byte_ext = {{(sohm_pkg::HASH_W-sohm_pkg::BYTE_W){i_key_byte[sohm_pkg::BYTE_W-1]}},
                       i_key_byte};
    assign sum_a = hash_base + byte_ext + seed_use;
    assign sum_b = sum_a + (sum_a << sohm_pkg::MIX_SHL);
    assign mixed = sum_b ^ (sum_b >> sohm_pkg::MIX_SHR);

    // finished key goes to the queue
    assign o_job_push = accept && i_last_byte;
    assign o_job.hash = mixed;
    assign o_job.size = size_use;

    // next key state
    always_comb begin
        n_hash   = r_hash;
        n_seed   = r_seed;
        n_size   = r_size;
        n_inside = r_inside;
        if (accept) begin
            if (i_last_byte) begin
                n_hash   = '0;
                n_inside = 1'b0;
            end else begin
                n_hash   = mixed;
                n_seed   = seed_use;
                n_size   = size_use;
                n_inside = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_seed   <= '0;
            r_size   <= sohm_pkg::SIZE_W'(1);
            r_inside <= 1'b0;
        end else begin
            r_hash   <= n_hash;
            r_seed   <= n_seed;
            r_size   <= n_size;
            r_inside <= n_inside;
        end
    end

endmodule

/* src/sohm_queue.sv */
// ----------------------------------------------------------------------------
// sohm_queue: job queue
// Small register queue of finished keys between the front end and the
// finalize/modulo back end, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module sohm_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sohm_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output sohm_pkg::t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sohm_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* src/sohm_back.sv */
// ----------------------------------------------------------------------------
// sohm_back: finalize and modulo
// Applies the final avalanche in two steps, then a one-bit-per-cycle
// restoring remainder against the table size, and holds the result in an
// output register.
// ----------------------------------------------------------------------------
module sohm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  sohm_pkg::t_job              i_job,
    output logic                        o_job_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sohm_pkg::HASH_W-1:0] o_full_hash,
    output logic [sohm_pkg::SIZE_W-1:0] o_bucket
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIN1 = 3'd1;
    localparam logic [2:0] ST_FIN2 = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [sohm_pkg::HASH_W-1:0]  r_work, n_work;
    logic [sohm_pkg::HASH_W-1:0]  r_full, n_full;
    logic [sohm_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [sohm_pkg::SIZE_W-1:0]  r_rem, n_rem;
    logic [sohm_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;
    logic [sohm_pkg::HASH_W-1:0]  r_out_hash, n_out_hash;
    logic [sohm_pkg::SIZE_W-1:0]  r_out_bucket, n_out_bucket;

    logic                         out_free;
    logic [sohm_pkg::HASH_W-1:0]  fin_a;
    logic [sohm_pkg::HASH_W-1:0]  fin_b;
    logic [sohm_pkg::HASH_W-1:0]  fin_c;
    logic [sohm_pkg::SIZE_W:0]    trial;
    logic [sohm_pkg::SIZE_W:0]    diff;
    logic                         take;

    assign out_free    = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_full_hash = r_out_hash;
    assign o_bucket    = r_out_bucket;
    assign o_job_pop   = (r_state == ST_IDLE) && i_job_valid;

    // avalanche steps
    assign fin_a = r_work + (r_work << sohm_pkg::FIN_SHL_A);
    assign fin_b = fin_a ^ (fin_a >> sohm_pkg::FIN_SHR);
    assign fin_c = r_work + (r_work << sohm_pkg::FIN_SHL_B);

    // one remainder bit per cycle
    assign trial = {r_rem, r_work[sohm_pkg::HASH_W-1]};
    assign diff  = trial - {1'b0, r_size};
    assign take  = (trial >= {1'b0, r_size});

    always_comb begin
        n_state      = r_state;
        n_work       = r_work;
        n_full       = r_full;
        n_size       = r_size;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_hash   = r_out_hash;
        n_out_bucket = r_out_bucket;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_work  = i_job.hash;
                    n_size  = i_job.size;
                    n_state = ST_FIN1;
                end
            end
            ST_FIN1: begin
                n_work  = fin_b;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                n_work  = fin_c;
                n_full  = fin_c;
                n_rem   = '0;
                n_cnt   = sohm_pkg::CNT_W'(sohm_pkg::HASH_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem  = take ? diff[sohm_pkg::SIZE_W-1:0] : trial[sohm_pkg::SIZE_W-1:0];
                n_work = r_work << 1;
                n_cnt  = r_cnt - sohm_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_hash   = r_full;
                    n_out_bucket = (r_size == '0) ? '0 : r_rem;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_work       <= n_work;
        r_full       <= n_full;
        r_size       <= n_size;
        r_rem        <= n_rem;
        r_out_hash   <= n_out_hash;
        r_out_bucket <= n_out_bucket;
    end

    // remainder stays below a nonzero divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_size != '0) |-> (r_rem < r_size))
        else $error("remainder out of range");

    // the division runs out after its last bit
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == '0) |=> (r_state == ST_DONE))
        else $error("division did not end");

    // a finished result lands in the output register
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("result not loaded");

    // no job is taken while one is in flight
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_job_pop)
        else $error("job popped while busy");

endmodule

/* src/seeded_one_at_a_time_hash_mod_unit.sv */
// ----------------------------------------------------------------------------
// seeded_one_at_a_time_hash_mod_unit: seeded one-at-a-time hash with bucket
// Streams key bytes in, gives the finalized 32-bit hash and hash mod size.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one key byte per beat, with seed
//   and table size sampled on a key's first byte and i_last_byte marking the
//   final byte. Key bytes go in at one per cycle while the job queue has room.
//   Output channel (o_valid / i_ready) gives one beat per key: o_full_hash and
//   o_bucket (zero when the table size is zero).
//   A key's result passes through the queue, the two avalanche steps, the
//   bit-serial remainder and the output register.
//   The one-bit-per-cycle remainder unit finishes one key before it takes
//   the next; bytes of further keys keep flowing into the queue.
//   Reset clears the key in progress, the queue and the output register.
//   When the receiver stalls the result is held; the back end finishes the
//   next key and waits, the queue fills, then o_ready drops.
// ----------------------------------------------------------------------------
module seeded_one_at_a_time_hash_mod_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sohm_pkg::BYTE_W-1:0] i_key_byte,
    input  logic [sohm_pkg::HASH_W-1:0] i_seed,
    input  logic [sohm_pkg::SIZE_W-1:0] i_table_size,
    input  logic                        i_last_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sohm_pkg::HASH_W-1:0] o_full_hash,
    output logic [sohm_pkg::SIZE_W-1:0] o_bucket
);

    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_not_empty;
    sohm_pkg::t_job job_in;
    sohm_pkg::t_job job_out;

    // byte mixing
    sohm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key_byte   (i_key_byte),
        .i_seed       (i_seed),
        .i_table_size (i_table_size),
        .i_last_byte  (i_last_byte),
        .i_job_full   (job_full),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    // finished keys
    sohm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (job_push),
        .i_job       (job_in),
        .o_full      (job_full),
        .i_pop       (job_pop),
        .o_not_empty (job_not_empty),
        .o_job       (job_out)
    );

    // finalize and modulo
    sohm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_not_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_full_hash (o_full_hash),
        .o_bucket    (o_bucket)
    );

endmodule

/* bench/seeded_one_at_a_time_hash_mod_unit_checker.sv */
// ----------------------------------------------------------------------------
// seeded_one_at_a_time_hash_mod_unit_checker: result checker
// Watches both channels of the hash unit. Every accepted key byte is run
// through a bit-true one-at-a-time hash predictor with its own key state. On a
// last byte the predicted digest is queued. Every result beat is compared,
// field by field, with the oldest queued digest. The checker reports the
// mismatch count (unexpected beats included) and the digests still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seeded_one_at_a_time_hash_mod_unit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [sohm_pkg::BYTE_W-1:0] i_key_byte,
    input  logic [sohm_pkg::HASH_W-1:0] i_seed,
    input  logic [sohm_pkg::SIZE_W-1:0] i_table_size,
    input  logic                        i_last_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [sohm_pkg::HASH_W-1:0] i_full_hash,
    input  logic [sohm_pkg::SIZE_W-1:0] i_bucket,
    output int                          o_err_count,
    output int                          o_pending
);

    localparam int HW = sohm_pkg::HASH_W;
    localparam int SW = sohm_pkg::SIZE_W;
    localparam int BW = sohm_pkg::BYTE_W;

    typedef struct {
        logic [HW-1:0] full_hash;
        logic [SW-1:0] bucket;
    } t_digest;

    // key state of the predictor
    logic [HW-1:0] run_hash;
    logic [HW-1:0] key_seed;
    logic [SW-1:0] key_size;
    bit            key_open;

    t_digest       pending_digests[$];
    t_digest       new_digest;
    t_digest       oldest;
    logic [HW-1:0] final_hash;

    // add one sign-extended byte plus seed, then shift-add / xor-shift mix
    function automatic logic [HW-1:0] mix_byte(logic [HW-1:0] h, logic [BW-1:0] b,
                                               logic [HW-1:0] s);
        logic [HW-1:0] x;
        x = h + {{(HW-BW){b[BW-1]}}, b} + s;
        x = x + (x << 10);
        x = x ^ (x >> 6);
        return x;
    endfunction

    // end-of-key avalanche
    function automatic logic [HW-1:0] avalanche(logic [HW-1:0] h);
        logic [HW-1:0] x;
        x = h + (h << 3);
        x = x ^ (x >> 11);
        x = x + (x << 15);
        return x;
    endfunction

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_hash = '0;
            key_seed = '0;
            key_size = SW'(1);
            key_open = 1'b0;
            pending_digests.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_digests.size() == 0) begin
                    $display("%0t: unexpected result beat, full_hash %08h bucket %0d",
                             $time, i_full_hash, i_bucket);
                    o_err_count = o_err_count + 1;
                end else begin
                    oldest = pending_digests.pop_front();
                    if (i_full_hash !== oldest.full_hash) begin
                        $display("%0t: full_hash mismatch, expected %08h, actual %08h",
                                 $time, oldest.full_hash, i_full_hash);
                        o_err_count = o_err_count + 1;
                    end
                    if (i_bucket !== oldest.bucket) begin
                        $display("%0t: bucket mismatch, expected %0d, actual %0d",
                                 $time, oldest.bucket, i_bucket);
                        o_err_count = o_err_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                // seed and size are latched on the first byte of a key only
                if (!key_open) begin
                    run_hash = '0;
                    key_seed = i_seed;
                    key_size = i_table_size;
                    key_open = 1'b1;
                end
                run_hash = mix_byte(run_hash, i_key_byte, key_seed);
                if (i_last_byte) begin
                    final_hash           = avalanche(run_hash);
                    new_digest.full_hash = final_hash;
                    new_digest.bucket    = (key_size == 0) ? '0 :
                                           SW'(final_hash % HW'(key_size));
                    pending_digests.push_back(new_digest);
                    run_hash = '0;
                    key_open = 1'b0;
                end
            end
        end
        o_pending = pending_digests.size();
    end

endmodule

/* bench/seeded_one_at_a_time_hash_mod_unit_tb.sv */
// ----------------------------------------------------------------------------
// seeded_one_at_a_time_hash_mod_unit_tb: testbench top
// Streams directed and random keys into the hash unit under changing idle
// patterns on both channels, including a long receiver hold-off and a full
// drain, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seeded_one_at_a_time_hash_mod_unit_tb;

    localparam int HW          = sohm_pkg::HASH_W;
    localparam int SW          = sohm_pkg::SIZE_W;
    localparam int BW          = sohm_pkg::BYTE_W;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [BW-1:0] i_key_byte;
    logic [HW-1:0] i_seed;
    logic [SW-1:0] i_table_size;
    logic          i_last_byte;
    logic          o_valid;
    logic          i_ready;
    logic [HW-1:0] o_full_hash;
    logic [SW-1:0] o_bucket;

    int err_count;
    int pending;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_served   = 1'b0;

    seeded_one_at_a_time_hash_mod_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key_byte   (i_key_byte),
        .i_seed       (i_seed),
        .i_table_size (i_table_size),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_full_hash  (o_full_hash),
        .o_bucket     (o_bucket)
    );

    seeded_one_at_a_time_hash_mod_unit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_key_byte   (i_key_byte),
        .i_seed       (i_seed),
        .i_table_size (i_table_size),
        .i_last_byte  (i_last_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_full_hash  (o_full_hash),
        .i_bucket     (o_bucket),
        .o_err_count  (err_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("seeded_one_at_a_time_hash_mod_unit_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // byte values leaning on the sign boundary and the extremes
    function automatic logic [BW-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return BW'($urandom_range(0, 255));
        endcase
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(logic [BW-1:0] b, logic [HW-1:0] s, logic [SW-1:0] z,
                             logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_key_byte   <= b;
        i_seed       <= s;
        i_table_size <= z;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // one key; seed and size on later bytes are noise the block must ignore
    task automatic send_key(int len, logic [HW-1:0] s, logic [SW-1:0] z);
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                send_beat(pick_byte(), s, z, len == 1);
            else
                send_beat(pick_byte(), ($urandom_range(0, 3) == 0) ? s : $urandom,
                          SW'($urandom_range(0, 65535)), i == len - 1);
        end
    endtask

    // sender stops and waits for every outstanding result
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // random keys until the byte goal is reached
    task automatic run_phase(int send_pct, int recv_pct, int byte_goal);
        int            len;
        logic [HW-1:0] s;
        logic [SW-1:0] z;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (bytes_sent < byte_goal) begin
            case ($urandom_range(0, 19))
                0, 1:    len = $urandom_range(7, 16);
                2:       len = $urandom_range(17, 40);
                default: len = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 7))
                0:       s = '0;
                1:       s = '1;
                default: s = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       z = '0;
                1:       z = SW'(1);
                2:       z = '1;
                3, 4:    z = SW'($urandom_range(2, 16));
                default: z = SW'($urandom_range(0, 65535));
            endcase
            send_key(len, s, z);
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_key_byte   = '0;
        i_seed       = '0;
        i_table_size = '0;
        i_last_byte  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 27;
        recv_idle_pct = 50;

        // single-byte keys at the field extremes, zero table size among them
        send_beat(8'h00, 32'h0000_0000, 16'd1, 1'b1);
        send_beat(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_beat(8'h80, 32'h8000_0000, 16'd0, 1'b1);
        send_beat(8'h7F, 32'h0000_0001, 16'd2, 1'b1);
        send_beat(8'h01, 32'h5555_5555, 16'h8000, 1'b1);
        // zero bytes inside a key do not end it
        send_beat(8'h00, 32'h1234_5678, 16'd1000, 1'b0);
        send_beat(8'h00, 32'h1234_5678, 16'd1000, 1'b0);
        send_beat(8'h00, 32'h1234_5678, 16'd1000, 1'b1);
        // seed and size changing inside a key are ignored
        send_beat(8'hA5, 32'hDEAD_BEEF, 16'd7, 1'b0);
        send_beat(8'h5A, 32'h0000_0000, 16'd0, 1'b0);
        send_beat(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_beat(8'h80, 32'h0F0F_0F0F, 16'd3, 1'b1);
        // two-byte key with zero size
        send_beat(8'h01, 32'hFFFF_FFFF, 16'd0, 1'b0);
        send_beat(8'hFE, 32'hAAAA_AAAA, 16'h5555, 1'b1);
        // two-byte key with max size; size one on the last byte is ignored
        send_beat(8'h7F, 32'hAAAA_AAAA, 16'hFFFF, 1'b0);
        send_beat(8'h80, 32'h5555_5555, 16'd1, 1'b1);
        wait_drained();

        // long receiver hold-off while keys keep coming
        hold_req = 1'b1;
        run_phase(27, 50, 230);
        run_phase(50, 27, 440);
        run_phase(0, 0, 650);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0)
            $display("seeded_one_at_a_time_hash_mod_unit_tb: done, clean");
        else
            $display("seeded_one_at_a_time_hash_mod_unit_tb: done, errors");
        $finish;
    end

endmodule
